// File: src/eada_pkg.sv
// Shared types, constants and register codes for the envelope adaptive decay attenuator.
// No dependencies; every other file imports this package.
`default_nettype none

package eada_pkg;

	// Sample format Q1.(SAMPLE_BITS-1)
	localparam int SAMPLE_BITS = 24;

	// Mask format Q1.15
	localparam int MASK_W    = 16;
	localparam int MASK_FRAC = 15;
	localparam logic [MASK_W-1:0] UNITY      = 16'd32768;
	localparam logic [MASK_W-1:0] MASK_FLOOR = 16'd655;

	// Configuration registers
	localparam int STRENGTH_W = 16;
	localparam int HOST_W     = 16;
	localparam int ALPHA_W    = 15;
	localparam int REL_W      = 24;
	localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 15'd327;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 15'd16384;
	localparam logic [REL_W-1:0]   REL_RESET   = 24'd16769451;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOST     = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE  = 8'd3;

	// Envelope threshold: round(2^(SAMPLE_BITS-1) / 1e6)
	localparam longint unsigned ENV_EPS =
		((64'd1 << (SAMPLE_BITS - 1)) + 64'd500000) / 64'd1000000;

	// Serial multiplier: radix-4, multiplier operand consumed two bits per cycle
	localparam int MUL_A_W     = SAMPLE_BITS;
	localparam int MUL_B_W     = REL_W;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int MUL_STEPS   = MUL_B_W / 2;
	localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

	// Divider quotient mag*2^30/(env+eps) and its square root
	localparam int QUO_W   = 2 * MASK_FRAC;
	localparam int ROOT_W  = MASK_FRAC;
	localparam int DEN_W   = SAMPLE_BITS + 1;
	localparam int DS_CNT_W = $clog2(QUO_W);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          block_end;
	} eada_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          block_last;
	} eada_out_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                   start;
		logic [SAMPLE_BITS-1:0] num;
		logic [DEN_W-1:0]       den;
	} ds_req_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_ROOT
	} ds_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV,
		ST_ENV_MUL,
		ST_DIV,
		ST_ROOT,
		ST_SMOOTH,
		ST_SMOOTH_MUL,
		ST_GAIN,
		ST_GAIN_MUL,
		ST_OUT,
		ST_OUT_MUL
	} eada_state_t;

endpackage

`default_nettype wire

// File: src/eada_smul.sv
// Radix-4 shift-and-add multiplier: one two-bit digit of b per cycle, LSB first.
// Depends on eada_pkg for operand widths and the request struct.
`default_nettype none

module eada_smul import eada_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mul_req_t           req,
	output logic                    busy,
	output logic [MUL_P_W-1:0]      prod
);

	logic                 busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_A_W+1:0]   a3_q;
	logic [MUL_A_W-1:0]   hi_q;
	logic [MUL_B_W-1:0]   lo_q;
	logic [MUL_A_W+1:0]   addend;
	logic [MUL_A_W+1:0]   sum;

	always_comb begin
		case (lo_q[1:0])
			2'd0:    addend = '0;
			2'd1:    addend = {2'b00, a_q};
			2'd2:    addend = {1'b0, a_q, 1'b0};
			2'd3:    addend = a3_q;
			default: addend = '0;
		endcase
		sum = {2'b00, hi_q} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			a3_q <= {2'b00, req.a} + {1'b0, req.a, 1'b0};
			hi_q <= '0;
			lo_q <= req.b;
		end else if (busy_q) begin
			// shift the partial product right by one digit
			hi_q <= sum[MUL_A_W+1:2];
			lo_q <= {sum[1:0], lo_q[MUL_B_W-1:2]};
		end
	end

	assign busy = busy_q;
	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

// File: src/eada_divsqrt.sv
// Restoring divider for num*2^30/den followed by a bit-pair square root of the quotient.
// Depends on eada_pkg; one quotient bit per cycle, then one root bit per cycle.
`default_nettype none

module eada_divsqrt import eada_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ds_req_t           req,
	output logic                   busy,
	output logic [ROOT_W-1:0]      root
);

	ds_state_t            state_q, state_d;
	logic [DS_CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [QUO_W-1:0]     quo_q;
	logic [ROOT_W+1:0]    rrem_q;
	logic [ROOT_W-1:0]    root_q;

	logic                 last_step;
	logic                 div_step;
	logic                 root_step;
	logic [DEN_W:0]       dtrial;
	logic                 dge;
	logic [ROOT_W+3:0]    rcat;
	logic [ROOT_W+3:0]    rtrial;
	logic                 rge;
	logic [ROOT_W+3:0]    rdiff;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE: if (req.start) state_d = DS_DIV;
			DS_DIV:  if (cnt_q == DS_CNT_W'(QUO_W - 1)) state_d = DS_ROOT;
			DS_ROOT: if (cnt_q == DS_CNT_W'(ROOT_W - 1)) state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	// outputs and step enables
	always_comb begin
		busy      = (state_q != DS_IDLE);
		div_step  = (state_q == DS_DIV);
		root_step = (state_q == DS_ROOT);
		last_step = (state_d != state_q);
	end

	always_comb begin
		dtrial = {rem_q, 1'b0};
		dge    = (dtrial >= {1'b0, den_q});
		rcat   = {rrem_q, quo_q[QUO_W-1:QUO_W-2]};
		rtrial = {2'b00, root_q, 2'b01};
		rge    = (rcat >= rtrial);
		rdiff  = rcat - rtrial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (last_step || state_q == DS_IDLE)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DS_IDLE && req.start) begin
			rem_q  <= {1'b0, req.num};
			den_q  <= req.den;
			rrem_q <= '0;
			root_q <= '0;
		end else if (div_step) begin
			rem_q <= dge ? DEN_W'(dtrial - {1'b0, den_q}) : dtrial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], dge};
		end else if (root_step) begin
			// bring down two quotient bits, try (root*4+1)
			rrem_q <= rge ? rdiff[ROOT_W+1:0] : rcat[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], rge};
			quo_q  <= {quo_q[QUO_W-3:0], 2'b00};
		end
	end

	assign root = root_q;

endmodule

`default_nettype wire

// File: src/envelope_adaptive_decay_attenuator.sv
// Top level of the envelope adaptive decay attenuator: sequencer, state and config registers.
// Depends on eada_pkg, eada_smul (shared serial multiplier) and eada_divsqrt.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   in       | in_valid / in_stall  | in_data  (sample_in, block_end)
//   out      | out_valid / out_stall| out_data (sample_out, block_last)
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample at a time: the next sample is accepted only once the result is in the output
// register. The four multiplies share the radix-4 multiplier (issue, 12 digits, completion),
// the divider and root run 30 + 15 steps plus issue and completion, and the idle state takes
// the sample; an envelope jump skips the decay multiply, an envelope at or below epsilon
// skips the divider. The result waits in the output register under out_stall, which holds
// the sequencer. Reset zeroes the envelope, sets the mask to unity and config to defaults.
`default_nettype none

module envelope_adaptive_decay_attenuator import eada_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire eada_in_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output eada_out_t                   out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	eada_state_t state_q, state_d;

	logic [STRENGTH_W-1:0]  strength_q;
	logic [HOST_W-1:0]      host_q;
	logic [ALPHA_W-1:0]     alpha_q;
	logic [REL_W-1:0]       release_q;

	logic [SAMPLE_BITS-1:0] env_q;
	logic [MASK_W-1:0]      mask_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic                   last_q;
	logic [MASK_W-1:0]      adapt_q;
	logic [MASK_W-1:0]      gain_q;
	logic                   up_q;
	logic                   out_valid_q;
	eada_out_t              out_q;

	mul_req_t               mul_req;
	logic                   mul_busy;
	logic [MUL_P_W-1:0]     mul_prod;
	ds_req_t                ds_req;
	logic                   ds_busy;
	logic [ROOT_W-1:0]      ds_root;

	logic                   in_accept;
	logic                   out_free;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] in_mag;
	logic                   env_jump;
	logic                   env_active;
	logic [SAMPLE_BITS:0]   env_rnd;
	logic [SAMPLE_BITS-1:0] env_new;
	logic [MASK_W-1:0]      target;
	logic                   up;
	logic [MASK_W-1:0]      dmag;
	logic [MASK_W:0]        rnd15;
	logic [MASK_W-1:0]      step;
	logic [MASK_W:0]        mask_sum;
	logic [MASK_W-1:0]      mask_new;
	logic [MASK_W-1:0]      adapt_new;
	logic [SAMPLE_BITS:0]   y_rnd;
	logic [SAMPLE_BITS-1:0] y_mag;

	eada_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	eada_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.busy   (ds_busy),
		.root   (ds_root)
	);

	// datapath terms
	always_comb begin
		in_mag     = in_data.sample_in[SAMPLE_BITS-1] ?
			SAMPLE_BITS'(~in_data.sample_in + 1'b1) : SAMPLE_BITS'(in_data.sample_in);
		env_jump   = (mag_q >= env_q);
		env_active = (env_q > SAMPLE_BITS'(ENV_EPS));
		env_rnd    = {1'b0, mul_prod[MUL_P_W-1:REL_W]} + (SAMPLE_BITS+1)'(mul_prod[REL_W-1]);
		env_new    = mag_q + env_rnd[SAMPLE_BITS-1:0];

		target     = (host_q < adapt_q) ? host_q : adapt_q;
		up         = (target >= mask_q);
		dmag       = up ? (target - mask_q) : (mask_q - target);

		rnd15      = {1'b0, mul_prod[2*MASK_FRAC:MASK_FRAC]} + (MASK_W+1)'(mul_prod[MASK_FRAC-1]);
		step       = rnd15[MASK_W-1:0];
		mask_sum   = {1'b0, mask_q} + {1'b0, step};
		if (up_q)
			mask_new = (mask_sum > {1'b0, UNITY}) ? UNITY : mask_sum[MASK_W-1:0];
		else
			mask_new = (step > mask_q) ? '0 : (mask_q - step);

		adapt_new  = ({1'b0, ds_root} < MASK_FLOOR) ? MASK_FLOOR : {1'b0, ds_root};

		y_rnd      = {1'b0, mul_prod[SAMPLE_BITS+MASK_FRAC-1:MASK_FRAC]}
			+ (SAMPLE_BITS+1)'(mul_prod[MASK_FRAC-1]);
		y_mag      = y_rnd[SAMPLE_BITS-1:0];
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == ST_OUT_MUL) && !mul_busy && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (in_accept) state_d = ST_ENV;
			ST_ENV:        state_d = env_jump ? ST_DIV : ST_ENV_MUL;
			ST_ENV_MUL:    if (!mul_busy) state_d = ST_DIV;
			ST_DIV:        state_d = env_active ? ST_ROOT : ST_SMOOTH;
			ST_ROOT:       if (!ds_busy) state_d = ST_SMOOTH;
			ST_SMOOTH:     state_d = ST_SMOOTH_MUL;
			ST_SMOOTH_MUL: if (!mul_busy) state_d = ST_GAIN;
			ST_GAIN:       state_d = ST_GAIN_MUL;
			ST_GAIN_MUL:   if (!mul_busy) state_d = ST_OUT;
			ST_OUT:        state_d = ST_OUT_MUL;
			ST_OUT_MUL:    if (out_load) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake and unit requests
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		ds_req.start  = 1'b0;
		ds_req.num    = mag_q;
		ds_req.den    = {1'b0, env_q} + DEN_W'(ENV_EPS);
		case (state_q)
			ST_ENV: begin
				mul_req.start = !env_jump;
				mul_req.a     = env_q - mag_q;
				mul_req.b     = release_q;
			end
			ST_DIV: begin
				ds_req.start = env_active;
			end
			ST_SMOOTH: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_A_W'(dmag);
				mul_req.b     = MUL_B_W'(alpha_q);
			end
			ST_GAIN: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_A_W'(UNITY - mask_q);
				mul_req.b     = MUL_B_W'(strength_q);
			end
			ST_OUT: begin
				mul_req.start = 1'b1;
				mul_req.a     = mag_q;
				mul_req.b     = MUL_B_W'(gain_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration; strength, host and alpha saturated on write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= UNITY;
			host_q     <= UNITY;
			alpha_q    <= ALPHA_MAX;
			release_q  <= REL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STRENGTH: begin
					strength_q <= (cfg_data[STRENGTH_W-1:0] > UNITY) ? UNITY
						: cfg_data[STRENGTH_W-1:0];
				end
				CFG_HOST: begin
					if (cfg_data[HOST_W-1:0] > UNITY)
						host_q <= UNITY;
					else if (cfg_data[HOST_W-1:0] < MASK_FLOOR)
						host_q <= MASK_FLOOR;
					else
						host_q <= cfg_data[HOST_W-1:0];
				end
				CFG_ALPHA: begin
					if (cfg_data[ALPHA_W-1:0] > ALPHA_MAX)
						alpha_q <= ALPHA_MAX;
					else if (cfg_data[ALPHA_W-1:0] < ALPHA_MIN)
						alpha_q <= ALPHA_MIN;
					else
						alpha_q <= cfg_data[ALPHA_W-1:0];
				end
				CFG_RELEASE: begin
					release_q <= cfg_data[REL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// envelope and smoothed mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			mask_q <= UNITY;
		end else begin
			if (state_q == ST_ENV && env_jump)
				env_q <= mag_q;
			else if (state_q == ST_ENV_MUL && !mul_busy)
				env_q <= env_new;
			if (state_q == ST_SMOOTH_MUL && !mul_busy)
				mask_q <= mask_new;
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_q  <= in_mag;
			neg_q  <= in_data.sample_in[SAMPLE_BITS-1];
			last_q <= in_data.block_end;
		end
		if (state_q == ST_DIV && !env_active)
			adapt_q <= UNITY;
		else if (state_q == ST_ROOT && !ds_busy)
			adapt_q <= adapt_new;
		if (state_q == ST_SMOOTH)
			up_q <= up;
		if (state_q == ST_GAIN_MUL && !mul_busy)
			gain_q <= MASK_W'((MASK_W+1)'(UNITY) - rnd15);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sample_out <= neg_q ? (~y_mag + 1'b1) : y_mag;
			out_q.block_last <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
